/* rtl/camp_pkg.sv */
// Shared types, widths and helpers for the circular alpha mask premultiply unit.
// No dependencies.
package camp_pkg;

  // Configuration and geometry
  localparam logic [11:0] SIZE_RESET = 12'd256;
  localparam int          SIZE_W     = 13;            // clamped size, holds MAX_SIZE
  localparam logic [SIZE_W-1:0] MAX_SIZE = 13'd4096;
  localparam int          DELTA_W    = 14;            // doubled signed offset
  localparam int          DSQ_W      = 26;            // one squared offset
  localparam int          DIST_W     = 27;            // sum of two squares
  localparam int          BOUND_W    = 25;            // squared circle bounds

  // Square root: input is the rim distance (below 2^24) shifted by 16
  localparam int          RIM_D_W    = 24;
  localparam int          SQ_IN_W    = RIM_D_W + 16;
  localparam int          SQ_OUT_W   = SQ_IN_W / 2;
  localparam int          SQ_STEPS   = SQ_OUT_W;

  // Rim factor
  localparam int          RIM_N_W    = 11;
  localparam logic [RIM_N_W-1:0] RIM_SPAN = 11'd1536;  // 3 px * 2 * 256
  localparam logic [9:0]  RECIP3     = 10'd683;        // 2^11 / 3, rounded up

  // Region codes
  localparam logic [1:0]  REGION_OUT  = 2'd0;
  localparam logic [1:0]  REGION_RIM  = 2'd1;
  localparam logic [1:0]  REGION_IN   = 2'd2;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
  } pix_t;

  typedef struct packed {
    pix_t       pix;
    logic [1:0] region;
  } ctx_t;

  // Exact floor(x / 255) for any product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* rtl/circular_alpha_mask_premultiply_unit.sv */
// Circular alpha mask with antialiased rim and alpha premultiply, fully pipelined.
// Depends on camp_pkg.
//
// Input words pass the offset, square, distance and classify stages, the one-bit-per-stage
// square root pipeline and the tail stages. Throughput: one word per cycle unless stalled.
// The whole pipeline advances together; it holds only while the output word is stalled.
// Reset (rst_n low, synchronous) clears all valid bits and sets image_size to 256.
module circular_alpha_mask_premultiply_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_alpha_in,
  // output words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_alpha_out,
  output logic [1:0]  out_region
);
  import camp_pkg::*;

  localparam int NSTG = SQ_STEPS + 9;

  logic                      adv;
  logic [NSTG-1:0]           vld_r;
  logic [11:0]               image_size_r;
  logic [SIZE_W-1:0]         size_c;
  logic signed [DELTA_W-1:0] inner_c;
  logic [BOUND_W-1:0]        outer_sq_r, inner_sq_r;

  // stage 1..3
  logic signed [DELTA_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [DSQ_W-1:0]          dxx_r, dyy_r;
  logic [DIST_W-1:0]         dist_r;
  pix_t                      pix1_r, pix2_r, pix3_r;

  // stage 4 and square root steps
  logic [SQ_IN_W-1:0]        rem_r  [0:SQ_STEPS];
  logic [SQ_OUT_W-1:0]       root_r [0:SQ_STEPS];
  ctx_t                      ctx_r  [0:SQ_STEPS];
  logic [1:0]                region_nxt;

  // tail stages
  logic signed [SQ_OUT_W+1:0] num_c;
  logic [RIM_N_W-1:0]        n_r, n_nxt;
  ctx_t                      ctx25_r, ctx26_r;
  logic [18:0]               an_r;
  logic [19:0]               q3_c;
  logic [7:0]                alpha_r, alpha_nxt;
  logic [1:0]                region27_r, region28_r;
  pix_t                      pix27_r;
  logic [15:0]               pb_r, pg_r, pr_r;
  logic [7:0]                alpha28_r;

  // Advance the whole pipeline unless the output word is held
  assign adv      = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      image_size_r <= cfg_wdata;
    end
  end

  // Clamp size and keep the squared circle bounds ready
  always_comb begin
    size_c  = ({1'b0, image_size_r} > MAX_SIZE) ? MAX_SIZE : {1'b0, image_size_r};
    inner_c = $signed({{(DELTA_W-SIZE_W){1'b0}}, size_c}) - 14'sd6;
  end

  always_ff @(posedge clk) begin
    outer_sq_r <= BOUND_W'(size_c * size_c);
    inner_sq_r <= BOUND_W'(inner_c * inner_c);
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 1: doubled offsets from the circle center
  always_comb begin
    dx_nxt = $signed({1'b0, in_pos_x, 1'b1}) - $signed({{(DELTA_W-SIZE_W){1'b0}}, size_c});
    dy_nxt = $signed({1'b0, in_pos_y, 1'b1}) - $signed({{(DELTA_W-SIZE_W){1'b0}}, size_c});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      pix1_r <= '{b: in_blue_in, g: in_green_in, r: in_red_in, a: in_alpha_in};
    end
  end

  // Stage 2: squares; stage 3: squared distance
  always_ff @(posedge clk) begin
    if (adv) begin
      dxx_r  <= DSQ_W'(dx_r * dx_r);
      dyy_r  <= DSQ_W'(dy_r * dy_r);
      pix2_r <= pix1_r;
      dist_r <= DIST_W'(dxx_r) + DIST_W'(dyy_r);
      pix3_r <= pix2_r;
    end
  end

  // Stage 4: classify and seed the square root
  always_comb begin
    if (dist_r >= DIST_W'(outer_sq_r)) begin
      region_nxt = REGION_OUT;
    end else if (dist_r >= DIST_W'(inner_sq_r)) begin
      region_nxt = REGION_RIM;
    end else begin
      region_nxt = REGION_IN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= {dist_r[RIM_D_W-1:0], 16'b0};
      root_r[0] <= '0;
      ctx_r[0]  <= '{pix: pix3_r, region: region_nxt};
    end
  end

  // Square root, one result bit per stage, most significant first
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int BIT = SQ_STEPS - 1 - k;
    logic [SQ_IN_W:0] trial_c;
    logic             take_c;

    always_comb begin
      trial_c = ((SQ_IN_W+1)'(root_r[k]) << (BIT + 1)) + ((SQ_IN_W+1)'(1) << (2 * BIT));
      take_c  = {1'b0, rem_r[k]} >= trial_c;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (take_c) begin
          rem_r[k+1]  <= rem_r[k] - trial_c[SQ_IN_W-1:0];
          root_r[k+1] <= root_r[k] | (SQ_OUT_W'(1) << BIT);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
        ctx_r[k+1] <= ctx_r[k];
      end
    end
  end

  // Rim factor: size*256 minus distance, clamped to the rim span
  always_comb begin
    num_c = $signed({1'b0, size_c, 8'b0}) - $signed({2'b0, root_r[SQ_STEPS]});
    if (num_c < 0) begin
      n_nxt = '0;
    end else if (num_c > $signed({{(SQ_OUT_W+2-RIM_N_W){1'b0}}, RIM_SPAN})) begin
      n_nxt = RIM_SPAN;
    end else begin
      n_nxt = num_c[RIM_N_W-1:0];
    end
  end

  // Divide by 1536: shift by 512, then multiply by the reciprocal of 3
  assign q3_c = an_r[18:9] * RECIP3;

  always_comb begin
    case (ctx26_r.region)
      REGION_RIM: alpha_nxt = q3_c[18:11];
      REGION_IN:  alpha_nxt = ctx26_r.pix.a;
      default:    alpha_nxt = 8'd0;
    endcase
  end

  // Stages 25..29: rim alpha, premultiply, output word
  always_ff @(posedge clk) begin
    if (adv) begin
      n_r        <= n_nxt;
      ctx25_r    <= ctx_r[SQ_STEPS];
      an_r       <= 19'(ctx25_r.pix.a * n_r);
      ctx26_r    <= ctx25_r;
      alpha_r    <= alpha_nxt;
      region27_r <= ctx26_r.region;
      pix27_r    <= ctx26_r.pix;
      pb_r       <= pix27_r.b * alpha_r;
      pg_r       <= pix27_r.g * alpha_r;
      pr_r       <= pix27_r.r * alpha_r;
      alpha28_r  <= alpha_r;
      region28_r <= region27_r;
      out_blue_out  <= div255(pb_r);
      out_green_out <= div255(pg_r);
      out_red_out   <= div255(pr_r);
      out_alpha_out <= alpha28_r;
      out_region    <= region28_r;
    end
  end

  assign out_valid = vld_r[NSTG-1];

endmodule

/* tb/tb_circular_alpha_mask_premultiply_unit.sv */
`timescale 1ns / 100ps
// Self-checking bench for circular_alpha_mask_premultiply_unit: pixel words in, masked words out.
// Depends on camp_pkg and the unit itself; predicts each word in a small scoreboard class.
module tb_circular_alpha_mask_premultiply_unit;
  import camp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [1:0] region;
  } mask_word_t;

  // Predict masked pixels and match them against the words that leave the unit
  class mask_scoreboard;
    mask_word_t   expected_q[$];
    logic [11:0]  side;
    int           mismatches;

    function new();
      side = SIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_side(logic [11:0] v);
      side = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Integer square root, bit by bit from the top
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_pixel(logic [11:0] px, logic [11:0] py, logic [7:0] b, logic [7:0] g,
                             logic [7:0] r, logic [7:0] a);
      longint          s;
      longint          dx;
      longint          dy;
      longint          inner;
      longint          span;
      longint unsigned dsq;
      longint unsigned q;
      logic [7:0]      na;
      mask_word_t      w;
      s = longint'(side);
      if (s > longint'(MAX_SIZE)) s = longint'(MAX_SIZE);
      // doubled offsets from the image center
      dx = 2 * longint'(px) + 1 - s;
      dy = 2 * longint'(py) + 1 - s;
      dsq = longint'(dx * dx + dy * dy);
      inner = s - 6;
      if (dsq >= longint'(s * s)) begin
        w = '{8'd0, 8'd0, 8'd0, 8'd0, REGION_OUT};
      end else if (dsq >= longint'(inner * inner)) begin
        // scale alpha by how far inside the outer circle the pixel sits
        q = root_floor(dsq << 16);
        span = s * 256 - longint'(q);
        if (span < 0) span = 0;
        if (span > 1536) span = 1536;
        na = 8'((longint'(a) * span) / 1536);
        w.blue   = 8'((int'(b) * int'(na)) / 255);
        w.green  = 8'((int'(g) * int'(na)) / 255);
        w.red    = 8'((int'(r) * int'(na)) / 255);
        w.alpha  = na;
        w.region = REGION_RIM;
      end else begin
        w.blue   = 8'((int'(b) * int'(a)) / 255);
        w.green  = 8'((int'(g) * int'(a)) / 255);
        w.red    = 8'((int'(r) * int'(a)) / 255);
        w.alpha  = a;
        w.region = REGION_IN;
      end
      expected_q.push_back(w);
    endfunction

    function void check_word(mask_word_t got);
      mask_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word with none expected: b=%0d g=%0d r=%0d a=%0d region=%0d",
                   got.blue, got.green, got.red, got.alpha, got.region);
        return;
      end
      want = expected_q.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
          got.alpha !== want.alpha || got.region !== want.region) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected b=%0d g=%0d r=%0d a=%0d region=%0d, got b=%0d g=%0d r=%0d a=%0d region=%0d",
                   want.blue, want.green, want.red, want.alpha, want.region,
                   got.blue, got.green, got.red, got.alpha, got.region);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = 12'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pos_x = 12'd0;
  logic [11:0] in_pos_y = 12'd0;
  logic [7:0]  in_blue_in = 8'd0;
  logic [7:0]  in_green_in = 8'd0;
  logic [7:0]  in_red_in = 8'd0;
  logic [7:0]  in_alpha_in = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_red_out;
  logic [7:0]  out_alpha_out;
  logic [1:0]  out_region;

  mask_scoreboard sb;
  int             cur_size = 256;
  logic           calm = 1'b0;
  int             stall_left = 0;
  int             cycles = 0;

  circular_alpha_mask_premultiply_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_blue_in   (in_blue_in),
    .in_green_in  (in_green_in),
    .in_red_in    (in_red_in),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue_out (out_blue_out),
    .out_green_out(out_green_out),
    .out_red_out  (out_red_out),
    .out_alpha_out(out_alpha_out),
    .out_region   (out_region)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stall the output in bursts: mostly short, sometimes long
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end
        1, 2, 3, 4, 5, 6, 7: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        default: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(0, 6);
        end
      endcase
    end
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word('{out_blue_out, out_green_out, out_red_out, out_alpha_out, out_region});
  end

  // Drive one pixel word after an optional gap, hold it until accepted
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r, logic [7:0] a);
    int gap;
    int pick;
    gap = 0;
    pick = $urandom_range(0, 99);
    if (!calm) begin
      if (pick >= 97) gap = $urandom_range(10, 40);
      else if (pick >= 72) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pos_x    <= px;
    in_pos_y    <= py;
    in_blue_in  <= b;
    in_green_in <= g;
    in_red_in   <= r;
    in_alpha_in <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px, py, b, g, r, a);
  endtask

  // Drain the pipeline, then write a new image size
  task automatic load_image_size(logic [11:0] v, logic quiet);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    calm      <= quiet;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_side(v);
    cur_size = int'(v);
  endtask

  function automatic logic [7:0] pick_channel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Random pixels, biased toward the antialiased rim of the current circle
  task automatic drive_random_pixels(int count);
    int s;
    int mode;
    int px;
    int py;
    int dxv;
    int rr;
    int rem;
    int dyv;
    s = cur_size;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 99);
      if (s > 0 && mode < 50) begin
        // aim at a doubled radius near the circle edge and solve for the row
        px = $urandom_range(0, s - 1);
        dxv = 2 * px + 1 - s;
        rr = s + 1 - int'($urandom_range(0, 8));
        if (rr < 0) rr = 0;
        rem = rr * rr - dxv * dxv;
        if (rem < 0) rem = 0;
        dyv = int'(sb.root_floor(longint'(rem)));
        if ($urandom_range(0, 1)) dyv = -dyv;
        py = (s - 1 + dyv) / 2;
        if (py < 0) py = 0;
        if (py > 4095) py = 4095;
      end else if (s > 0 && mode < 80) begin
        px = $urandom_range(0, s - 1);
        py = $urandom_range(0, s - 1);
      end else if (mode < 95) begin
        px = $urandom_range(0, 4095);
        py = $urandom_range(0, 4095);
      end else begin
        px = $urandom_range(0, 1) ? 4095 : 0;
        py = $urandom_range(0, 1) ? ((s > 0) ? s - 1 : 0) : 4095;
      end
      send_pixel(12'(px), 12'(py), pick_channel(), pick_channel(), pick_channel(),
                 pick_channel());
    end
  endtask

  logic [11:0] size_plan[$];

  initial begin
    sb = new();
    size_plan = '{12'd4095, 12'd8, 12'd0, 12'd5, 12'd6, 12'd7, 12'd1, 12'd64, 12'd2049,
                  12'($urandom_range(9, 600)), 12'($urandom_range(0, 4095))};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Edge pixels at the reset size of 256
    send_pixel(12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd127, 12'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd128, 12'd128, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(12'd127, 12'd128, 8'hFF, 8'h80, 8'h01, 8'h00);
    send_pixel(12'd128, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd128, 12'd2, 8'hC8, 8'h37, 8'hFF, 8'hFF);
    send_pixel(12'd128, 12'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd0, 12'd128, 8'hFF, 8'hFF, 8'hFF, 8'h7F);
    send_pixel(12'd255, 12'd128, 8'h12, 8'h34, 8'h56, 8'hFF);
    send_pixel(12'd255, 12'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd37, 12'd37, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd40, 12'd40, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd300, 12'd128, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd128, 12'd2048, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pixel(12'd2730, 12'd1365, 8'h55, 8'hAA, 8'h55, 8'hAA);
    drive_random_pixels(70);

    // Walk through the size settings, with some phases free of gaps and stalls
    foreach (size_plan[i]) begin
      load_image_size(size_plan[i], (i % 4) == 2);
      drive_random_pixels(82);
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
